@@ rtl/core/ism_pkg.sv @@
// Package: shared constants and controller/datapath handshake structs.
`default_nettype none
package ism_pkg;

  localparam int unsigned MAX_INTERVALS_DEF = 64;
  localparam int unsigned POS_WIDTH_DEF     = 31;
  localparam int unsigned GAP_W             = 10;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // latch incoming transaction, start insertion search
    logic shift;       // move compared entry up one slot
    logic place;       // write new interval at current slot
    logic scan_start;  // read first stored entry
    logic run_load;    // take first entry as running interval
    logic step;        // merge or emit against next entry
    logic finish;      // emit final interval, clear list
  } ism_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic greater;     // compared entry start above new start
    logic pos_one;     // insertion slot is one
    logic last;        // list_last, live during load, else latched
    logic single;      // one interval stored
    logic scan_end;    // current compare is the last stored entry
  } ism_status_t;

endpackage
`default_nettype wire

@@ rtl/core/ism_ctrl.sv @@
// Controller: sequences insertion, merge scan and final emit.
`default_nettype none
module ism_ctrl (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start,
  output logic                     busy,
  input  wire ism_pkg::ism_status_t status_i,
  output ism_pkg::ism_cmd_t        cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_INS_CMP, S_PLACE, S_SCAN_START, S_SCAN_LOAD, S_SCAN, S_FINISH
  } state_e;

  state_e state_q, state_d;

  // Decode commands and next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (status_i.full) begin
            state_d = status_i.last ? S_SCAN_START : S_IDLE;
          end else if (status_i.empty) begin
            state_d = S_PLACE;
          end else begin
            state_d = S_INS_CMP;
          end
        end
      end
      S_INS_CMP: begin
        if (status_i.greater) begin
          cmd_o.shift = 1'b1;
          if (status_i.pos_one) state_d = S_PLACE;
        end else begin
          cmd_o.place = 1'b1;
          state_d = status_i.last ? S_SCAN_START : S_IDLE;
        end
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        state_d = status_i.last ? S_SCAN_START : S_IDLE;
      end
      S_SCAN_START: begin
        cmd_o.scan_start = 1'b1;
        state_d = S_SCAN_LOAD;
      end
      S_SCAN_LOAD: begin
        cmd_o.run_load = 1'b1;
        state_d = status_i.single ? S_FINISH : S_SCAN;
      end
      S_SCAN: begin
        cmd_o.step = 1'b1;
        if (status_i.scan_end) state_d = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

@@ rtl/core/ism_dpath.sv @@
// Datapath: sorted interval memory, insertion shifter, merge scan, output regs.
`default_nettype none
module ism_dpath #(
  parameter int unsigned MAX_INTERVALS = ism_pkg::MAX_INTERVALS_DEF,
  parameter int unsigned POS_WIDTH     = ism_pkg::POS_WIDTH_DEF
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire ism_pkg::ism_cmd_t   cmd_i,
  output ism_pkg::ism_status_t     status_o,
  input  wire [POS_WIDTH-1:0]      range_start_i,
  input  wire [POS_WIDTH-1:0]      range_end_i,
  input  wire                      list_last_i,
  input  wire                      link_gap_we_i,
  input  wire [ism_pkg::GAP_W-1:0] link_gap_i,
  output logic                     merged_valid_o,
  output logic [POS_WIDTH-1:0]     merged_start_o,
  output logic [POS_WIDTH-1:0]     merged_end_o,
  output logic                     merged_last_o,
  output logic                     dropped_flag_o
);

  localparam int unsigned IDX_W = $clog2(MAX_INTERVALS);
  localparam int unsigned CNT_W = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned ENT_W = 2 * POS_WIDTH;
  localparam int unsigned SUM_W =
    ((POS_WIDTH > ism_pkg::GAP_W) ? POS_WIDTH : ism_pkg::GAP_W) + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_INTERVALS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

  logic [ENT_W-1:0]          mem [MAX_INTERVALS];
  logic [ENT_W-1:0]          rdata_q;
  logic [IDX_W-1:0]          raddr;
  logic                      we;
  logic [IDX_W-1:0]          waddr;
  logic [ENT_W-1:0]          wdata;

  logic [POS_WIDTH-1:0]      s_q, e_q;
  logic                      last_q;
  logic [CNT_W-1:0]          pos_q, count_q, idx_q;
  logic                      ovf_q;
  logic [ism_pkg::GAP_W-1:0] gap_q;
  logic [POS_WIDTH-1:0]      run_s_q, run_e_q;

  logic [POS_WIDTH-1:0]      rd_s, rd_e;
  logic                      join_w;

  assign rd_s = rdata_q[ENT_W-1:POS_WIDTH];
  assign rd_e = rdata_q[POS_WIDTH-1:0];

  // Merge test: running end plus gap strictly above next start
  assign join_w = (SUM_W'(run_e_q) + SUM_W'(gap_q)) > SUM_W'(rd_s);

  // Status toward controller
  always_comb begin
    status_o.full     = (count_q == CNT_MAX);
    status_o.empty    = (count_q == '0);
    status_o.greater  = (rd_s > s_q);
    status_o.pos_one  = (pos_q == CNT_ONE);
    status_o.last     = cmd_i.load ? list_last_i : last_q;
    status_o.single   = (count_q == CNT_ONE);
    status_o.scan_end = (idx_q == count_q);
  end

  // Select read address
  always_comb begin
    raddr = idx_q[IDX_W-1:0];
    if (cmd_i.load)       raddr = IDX_W'(count_q - CNT_ONE);
    else if (cmd_i.shift) raddr = IDX_W'(pos_q - CNT_TWO);
    else if (cmd_i.scan_start) raddr = '0;
  end

  // Select write port
  assign we    = cmd_i.shift | cmd_i.place;
  assign waddr = pos_q[IDX_W-1:0];
  assign wdata = cmd_i.shift ? rdata_q : {s_q, e_q};

  // Interval memory
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // Latch transaction and running interval
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      s_q    <= range_start_i;
      e_q    <= range_end_i;
      last_q <= list_last_i;
    end
    if (cmd_i.run_load || (cmd_i.step && !join_w)) begin
      run_s_q <= rd_s;
      run_e_q <= rd_e;
    end else if (cmd_i.step && (rd_e > run_e_q)) begin
      run_e_q <= rd_e;
    end
  end

  // Control counters, flags and output transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q          <= '0;
      count_q        <= '0;
      idx_q          <= '0;
      ovf_q          <= 1'b0;
      gap_q          <= '0;
      merged_valid_o <= 1'b0;
      merged_start_o <= '0;
      merged_end_o   <= '0;
      merged_last_o  <= 1'b0;
      dropped_flag_o <= 1'b0;
    end else begin
      merged_valid_o <= 1'b0;
      if (link_gap_we_i) gap_q <= link_gap_i;
      if (cmd_i.load) begin
        pos_q <= count_q;
        if (count_q == CNT_MAX) ovf_q <= 1'b1;
      end
      if (cmd_i.shift) pos_q <= pos_q - CNT_ONE;
      if (cmd_i.place) count_q <= count_q + CNT_ONE;
      if (cmd_i.scan_start) idx_q <= CNT_ONE;
      if (cmd_i.run_load || cmd_i.step) idx_q <= idx_q + CNT_ONE;
      if (cmd_i.step && !join_w) begin
        merged_valid_o <= 1'b1;
        merged_start_o <= run_s_q;
        merged_end_o   <= run_e_q;
        merged_last_o  <= 1'b0;
        dropped_flag_o <= ovf_q;
      end
      if (cmd_i.finish) begin
        merged_valid_o <= 1'b1;
        merged_start_o <= run_s_q;
        merged_end_o   <= run_e_q;
        merged_last_o  <= 1'b1;
        dropped_flag_o <= ovf_q;
        count_q        <= '0;
        ovf_q          <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/interval_sort_and_merge.sv @@
// Top level: interval sort-and-merge block, controller plus datapath.
`default_nettype none
// Intervals enter one transaction at a time while busy is low. Each is placed
// in a sorted memory by insertion: the new interval is latched, then each
// stored entry whose start exceeds the new start is shifted up one slot, then
// the new interval is written; a dropped interval is only latched. On the
// transaction flagged list_last the merge scan reads the memory one entry per
// cycle, keeping busy high until the scan ends.
// Merged intervals appear on a one-cycle merged_valid_o strobe that the
// receiver must take at once; the final one carries merged_last_o. Intervals
// beyond MAX_INTERVALS are dropped and reported on dropped_flag_o with every
// result of that list.
module interval_sort_and_merge #(
  parameter int unsigned MAX_INTERVALS = ism_pkg::MAX_INTERVALS_DEF,
  parameter int unsigned POS_WIDTH     = ism_pkg::POS_WIDTH_DEF
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start,
  output logic                     busy,
  input  wire [POS_WIDTH-1:0]      range_start_i,
  input  wire [POS_WIDTH-1:0]      range_end_i,
  input  wire                      list_last_i,
  input  wire                      link_gap_we_i,
  input  wire [ism_pkg::GAP_W-1:0] link_gap_i,
  output logic                     merged_valid_o,
  output logic [POS_WIDTH-1:0]     merged_start_o,
  output logic [POS_WIDTH-1:0]     merged_end_o,
  output logic                     merged_last_o,
  output logic                     dropped_flag_o
);

  ism_pkg::ism_cmd_t    cmd;
  ism_pkg::ism_status_t status;

  ism_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  ism_dpath #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .POS_WIDTH     (POS_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .range_start_i  (range_start_i),
    .range_end_i    (range_end_i),
    .list_last_i    (list_last_i),
    .link_gap_we_i  (link_gap_we_i),
    .link_gap_i     (link_gap_i),
    .merged_valid_o (merged_valid_o),
    .merged_start_o (merged_start_o),
    .merged_end_o   (merged_end_o),
    .merged_last_o  (merged_last_o),
    .dropped_flag_o (dropped_flag_o)
  );

endmodule
`default_nettype wire
